>>> rtl/core/ncrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncrs_pkg;

    localparam int CLIP_DEPTH   = 16;
    localparam int OFFSET_DEPTH = 16;

    localparam int CLIP_CNT_W = $clog2(CLIP_DEPTH + 1);
    localparam int CLIP_IDX_W = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
    localparam int OFS_CNT_W  = $clog2(OFFSET_DEPTH + 1);
    localparam int OFS_IDX_W  = (OFFSET_DEPTH > 1) ? $clog2(OFFSET_DEPTH) : 1;

    // accumulated offset: sum of up to OFFSET_DEPTH signed 16-bit values
    localparam int OFS_W  = 17 + $clog2(OFFSET_DEPTH);
    // corners carry one offset subtract and one width add on top of that
    localparam int COR_W  = OFS_W + 2;
    // working width for differences and the y flip
    localparam int CALC_W = OFS_W + 4;

    localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'(32767);
    localparam logic signed [CALC_W-1:0] SAT_LO = CALC_W'(-32768);

    typedef enum logic [1:0] {
        OP_PUSH_CLIP = 2'd0,
        OP_POP_CLIP  = 2'd1,
        OP_PUSH_OFS  = 2'd2,
        OP_POP_OFS   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CLIP_FULL  = 3'd1,
        ST_CLIP_EMPTY = 3'd2,
        ST_OFS_FULL   = 3'd3,
        ST_OFS_EMPTY  = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } clip_rect_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } shift_t;

    function automatic logic signed [15:0] sat16(input logic signed [CALC_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI)
            r = 16'sh7FFF;
        else if (v < SAT_LO)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/nested_clip_rectangle_stack_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Scissor stack: nested clip rectangles plus a stack of x/y offsets. Every op
// (push/pop clip, push/pop offset) is one transfer: if unstalled, an item can be
// transferred on every clock, and its result shows up in the output register
// on the next cycle. The rate is set by the single intersection path from the
// input and state registers to the result register (offset subtract, min/max
// against the current corners, inversion compare, size subtract, y flip and
// saturation). Both stacks live in small memories with a registered read that
// is pointed ahead at the entry a pop will need, so pops also run every cycle.
// No clearing pass is needed after reset. window_height is taken on cfg_wr_en
// and should only change while the block is idle.
module nested_clip_rectangle_stack_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic signed [15:0] rect_w,
    input  logic signed [15:0] rect_h,
    input  logic signed [15:0] shift_x,
    input  logic signed [15:0] shift_y,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic               clip_enable,
    output logic signed [15:0] clip_x,
    output logic signed [15:0] clip_y,
    output logic signed [15:0] clip_w,
    output logic signed [15:0] clip_h
);

    localparam int CLIP_CNT_W = ncrs_pkg::CLIP_CNT_W;
    localparam int CLIP_IDX_W = ncrs_pkg::CLIP_IDX_W;
    localparam int OFS_CNT_W  = ncrs_pkg::OFS_CNT_W;
    localparam int OFS_IDX_W  = ncrs_pkg::OFS_IDX_W;
    localparam int OFS_W      = ncrs_pkg::OFS_W;
    localparam int COR_W      = ncrs_pkg::COR_W;
    localparam int CALC_W     = ncrs_pkg::CALC_W;

    // state
    logic [14:0]                  win_h_reg;
    logic [CLIP_CNT_W-1:0]        clip_cnt_reg, clip_cnt_next;
    logic [OFS_CNT_W-1:0]         ofs_cnt_reg, ofs_cnt_next;
    logic signed [OFS_W-1:0]      ofs_x_reg, ofs_x_next;
    logic signed [OFS_W-1:0]      ofs_y_reg, ofs_y_next;
    logic signed [COR_W-1:0]      lo_x_reg, lo_x_next;
    logic signed [COR_W-1:0]      lo_y_reg, lo_y_next;
    logic signed [COR_W-1:0]      hi_x_reg, hi_x_next;
    logic signed [COR_W-1:0]      hi_y_reg, hi_y_next;
    ncrs_pkg::clip_rect_t         top_reg, top_next;

    // stacks, plus prefetched entries: the one under the clip top, the offset top
    ncrs_pkg::clip_rect_t         clip_mem [ncrs_pkg::CLIP_DEPTH];
    ncrs_pkg::shift_t             ofs_mem  [ncrs_pkg::OFFSET_DEPTH];
    ncrs_pkg::clip_rect_t         under_reg;
    ncrs_pkg::shift_t             ofs_top_reg;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [2:0]                   status_reg;
    logic                         enable_reg;
    ncrs_pkg::clip_rect_t         res_reg;

    logic                         in_xfer;
    ncrs_pkg::op_t                op_in;
    ncrs_pkg::status_t            status_next;
    logic                         clip_we;
    logic                         ofs_we;
    logic [CLIP_CNT_W-1:0]        clip_rd_cnt;
    logic [OFS_CNT_W-1:0]         ofs_rd_cnt;

    // push-clip datapath
    logic signed [CALC_W-1:0]     hgt;
    logic signed [CALC_W-1:0]     lx, ly, rx, ry;
    logic signed [CALC_W-1:0]     nlo_x, nlo_y, nhi_x, nhi_y;
    logic signed [CALC_W-1:0]     nw, nh, ny;
    logic                         inverted;
    ncrs_pkg::clip_rect_t         push_rect;

    // pop-clip corner rebuild
    logic signed [CALC_W-1:0]     plo_x, plo_y, phi_x, phi_y;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign op_in    = ncrs_pkg::op_t'(op);
    assign hgt      = CALC_W'(win_h_reg);

    always_comb
    begin
        lx = CALC_W'(rect_x) - CALC_W'(ofs_x_reg);
        ly = CALC_W'(rect_y) - CALC_W'(ofs_y_reg);
        rx = lx + CALC_W'(rect_w);
        ry = ly + CALC_W'(rect_h);
        if (clip_cnt_reg == '0)
        begin
            nlo_x = lx;
            nlo_y = ly;
            nhi_x = rx;
            nhi_y = ry;
        end
        else
        begin
            nlo_x = (CALC_W'(lo_x_reg) > lx) ? CALC_W'(lo_x_reg) : lx;
            nlo_y = (CALC_W'(lo_y_reg) > ly) ? CALC_W'(lo_y_reg) : ly;
            nhi_x = (CALC_W'(hi_x_reg) < rx) ? CALC_W'(hi_x_reg) : rx;
            nhi_y = (CALC_W'(hi_y_reg) < ry) ? CALC_W'(hi_y_reg) : ry;
        end
        inverted = (nlo_x > nhi_x) || (nlo_y > nhi_y);
        nw = inverted ? '0 : (nhi_x - nlo_x);
        nh = inverted ? '0 : (nhi_y - nlo_y);
        ny = hgt - nlo_y - nh;
        push_rect.x = ncrs_pkg::sat16(nlo_x);
        push_rect.y = ncrs_pkg::sat16(ny);
        push_rect.w = ncrs_pkg::sat16(nw);
        push_rect.h = ncrs_pkg::sat16(nh);

        // corners rebuilt from the saturated entry that becomes the top
        plo_x = CALC_W'(under_reg.x);
        plo_y = hgt - CALC_W'(under_reg.y) - CALC_W'(under_reg.h);
        phi_x = plo_x + CALC_W'(under_reg.w);
        phi_y = plo_y + CALC_W'(under_reg.h);
    end

    always_comb
    begin
        clip_cnt_next = clip_cnt_reg;
        ofs_cnt_next  = ofs_cnt_reg;
        ofs_x_next    = ofs_x_reg;
        ofs_y_next    = ofs_y_reg;
        lo_x_next     = lo_x_reg;
        lo_y_next     = lo_y_reg;
        hi_x_next     = hi_x_reg;
        hi_y_next     = hi_y_reg;
        top_next      = top_reg;
        status_next   = ncrs_pkg::ST_OK;
        clip_we       = 1'b0;
        ofs_we        = 1'b0;
        case (op_in)
            ncrs_pkg::OP_PUSH_CLIP:
            begin
                if (clip_cnt_reg == CLIP_CNT_W'(ncrs_pkg::CLIP_DEPTH))
                    status_next = ncrs_pkg::ST_CLIP_FULL;
                else
                begin
                    clip_we       = in_xfer;
                    clip_cnt_next = clip_cnt_reg + 1'b1;
                    lo_x_next     = COR_W'(nlo_x);
                    lo_y_next     = COR_W'(nlo_y);
                    hi_x_next     = COR_W'(nhi_x);
                    hi_y_next     = COR_W'(nhi_y);
                    top_next      = push_rect;
                end
            end
            ncrs_pkg::OP_POP_CLIP:
            begin
                if (clip_cnt_reg == '0)
                    status_next = ncrs_pkg::ST_CLIP_EMPTY;
                else
                begin
                    clip_cnt_next = clip_cnt_reg - 1'b1;
                    // popping the last entry leaves the corners alone
                    if (clip_cnt_reg != CLIP_CNT_W'(1))
                    begin
                        lo_x_next = COR_W'(plo_x);
                        lo_y_next = COR_W'(plo_y);
                        hi_x_next = COR_W'(phi_x);
                        hi_y_next = COR_W'(phi_y);
                        top_next  = under_reg;
                    end
                end
            end
            ncrs_pkg::OP_PUSH_OFS:
            begin
                if (ofs_cnt_reg == OFS_CNT_W'(ncrs_pkg::OFFSET_DEPTH))
                    status_next = ncrs_pkg::ST_OFS_FULL;
                else
                begin
                    ofs_we       = in_xfer;
                    ofs_cnt_next = ofs_cnt_reg + 1'b1;
                    ofs_x_next   = ofs_x_reg + OFS_W'(shift_x);
                    ofs_y_next   = ofs_y_reg + OFS_W'(shift_y);
                end
            end
            ncrs_pkg::OP_POP_OFS:
            begin
                if (ofs_cnt_reg == '0)
                    status_next = ncrs_pkg::ST_OFS_EMPTY;
                else
                begin
                    ofs_cnt_next = ofs_cnt_reg - 1'b1;
                    ofs_x_next   = ofs_x_reg - OFS_W'(ofs_top_reg.x);
                    ofs_y_next   = ofs_y_reg - OFS_W'(ofs_top_reg.y);
                end
            end
            default:
            begin
                status_next = ncrs_pkg::ST_OK;
            end
        endcase
    end

    // read-ahead addresses follow the count after this cycle's transfer
    always_comb
    begin
        if (in_xfer)
        begin
            clip_rd_cnt = clip_cnt_next - CLIP_CNT_W'(2);
            ofs_rd_cnt  = ofs_cnt_next - OFS_CNT_W'(1);
        end
        else
        begin
            clip_rd_cnt = clip_cnt_reg - CLIP_CNT_W'(2);
            ofs_rd_cnt  = ofs_cnt_reg - OFS_CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (in_xfer)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clip_we)
            clip_mem[clip_cnt_reg[CLIP_IDX_W-1:0]] <= push_rect;
        under_reg <= clip_mem[clip_rd_cnt[CLIP_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ofs_we)
            ofs_mem[ofs_cnt_reg[OFS_IDX_W-1:0]] <= '{x: shift_x, y: shift_y};
        // a push reads the entry being written: take it from the input
        if (ofs_we)
            ofs_top_reg <= '{x: shift_x, y: shift_y};
        else
            ofs_top_reg <= ofs_mem[ofs_rd_cnt[OFS_IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_h_reg     <= '0;
            clip_cnt_reg  <= '0;
            ofs_cnt_reg   <= '0;
            ofs_x_reg     <= '0;
            ofs_y_reg     <= '0;
            lo_x_reg      <= '0;
            lo_y_reg      <= '0;
            hi_x_reg      <= '0;
            hi_y_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                win_h_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                clip_cnt_reg <= clip_cnt_next;
                ofs_cnt_reg  <= ofs_cnt_next;
                ofs_x_reg    <= ofs_x_next;
                ofs_y_reg    <= ofs_y_next;
                lo_x_reg     <= lo_x_next;
                lo_y_reg     <= lo_y_next;
                hi_x_reg     <= hi_x_next;
                hi_y_reg     <= hi_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            top_reg    <= top_next;
            status_reg <= status_next;
            enable_reg <= (clip_cnt_next != '0);
            if (clip_cnt_next == '0)
                res_reg <= '0;
            else
                res_reg <= top_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign clip_enable = enable_reg;
    assign clip_x      = res_reg.x;
    assign clip_y      = res_reg.y;
    assign clip_w      = res_reg.w;
    assign clip_h      = res_reg.h;

    // the shown enable tracks the clip stack fill between transfers
    a_enable_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (enable_reg == (clip_cnt_reg != '0)))
        else $error("clip_enable out of step with clip stack fill");

    a_clip_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clip_cnt_reg <= CLIP_CNT_W'(ncrs_pkg::CLIP_DEPTH))
        else $error("clip stack fill beyond depth");

    a_ofs_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ofs_cnt_reg <= OFS_CNT_W'(ncrs_pkg::OFFSET_DEPTH))
        else $error("offset stack fill beyond depth");

    a_full_push_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && op_in == ncrs_pkg::OP_PUSH_CLIP
            && clip_cnt_reg == CLIP_CNT_W'(ncrs_pkg::CLIP_DEPTH))
        |=> (clip_cnt_reg == $past(clip_cnt_reg)) && (status_reg == ncrs_pkg::ST_CLIP_FULL))
        else $error("push on full clip stack changed state");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !enable_reg) |-> (res_reg == '0))
        else $error("clip fields not zero with empty clip stack");

endmodule

`default_nettype wire

>>> sim/nested_clip_rectangle_stack_core_tb.sv
`timescale 1ns / 1ps

module nested_clip_rectangle_stack_core_tb;

    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        ncrs_pkg::op_t op;
        shortint       rect_x;
        shortint       rect_y;
        shortint       rect_w;
        shortint       rect_h;
        shortint       shift_x;
        shortint       shift_y;
    } stack_op_t;

    typedef struct {
        ncrs_pkg::status_t status;
        bit                enable;
        shortint           x;
        shortint           y;
        shortint           w;
        shortint           h;
    } clip_view_t;

    // Tracks both stacks and the exact corners, and queues the clip view
    // expected after every accepted transfer.
    class scissor_tracker;
        shortint    box_x[ncrs_pkg::CLIP_DEPTH];
        shortint    box_y[ncrs_pkg::CLIP_DEPTH];
        shortint    box_w[ncrs_pkg::CLIP_DEPTH];
        shortint    box_h[ncrs_pkg::CLIP_DEPTH];
        shortint    ofs_x[ncrs_pkg::OFFSET_DEPTH];
        shortint    ofs_y[ncrs_pkg::OFFSET_DEPTH];
        int         clip_cnt;
        int         ofs_cnt;
        longint     sum_x;
        longint     sum_y;
        longint     lo_x;
        longint     lo_y;
        longint     hi_x;
        longint     hi_y;
        longint     height;
        clip_view_t pending_views[$];
        int         mismatches;

        function shortint clamp16(longint v);
            if (v > 32767)
                return 16'sh7FFF;
            if (v < -32768)
                return 16'sh8000;
            return shortint'(v);
        endfunction

        function void apply_op(stack_op_t it);
            longint     lx;
            longint     ly;
            longint     nw;
            longint     nh;
            clip_view_t v;
            v.status = ncrs_pkg::ST_OK;
            case (it.op)
                ncrs_pkg::OP_PUSH_CLIP:
                    if (clip_cnt >= ncrs_pkg::CLIP_DEPTH)
                        v.status = ncrs_pkg::ST_CLIP_FULL;
                    else
                    begin
                        lx = longint'(it.rect_x) - sum_x;
                        ly = longint'(it.rect_y) - sum_y;
                        if (clip_cnt == 0)
                        begin
                            lo_x = lx;
                            lo_y = ly;
                            hi_x = lx + longint'(it.rect_w);
                            hi_y = ly + longint'(it.rect_h);
                        end
                        else
                        begin
                            if (lx > lo_x) lo_x = lx;
                            if (ly > lo_y) lo_y = ly;
                            if (lx + longint'(it.rect_w) < hi_x) hi_x = lx + longint'(it.rect_w);
                            if (ly + longint'(it.rect_h) < hi_y) hi_y = ly + longint'(it.rect_h);
                        end
                        // inverted: size zero, corners stay as computed
                        if (lo_x > hi_x || lo_y > hi_y)
                        begin
                            nw = 0;
                            nh = 0;
                        end
                        else
                        begin
                            nw = hi_x - lo_x;
                            nh = hi_y - lo_y;
                        end
                        box_x[clip_cnt] = clamp16(lo_x);
                        box_y[clip_cnt] = clamp16(height - lo_y - nh);
                        box_w[clip_cnt] = clamp16(nw);
                        box_h[clip_cnt] = clamp16(nh);
                        clip_cnt++;
                    end
                ncrs_pkg::OP_POP_CLIP:
                    if (clip_cnt == 0)
                        v.status = ncrs_pkg::ST_CLIP_EMPTY;
                    else
                    begin
                        clip_cnt--;
                        // corners come back from the saturated entry below
                        if (clip_cnt != 0)
                        begin
                            lo_x = box_x[clip_cnt - 1];
                            lo_y = height - longint'(box_y[clip_cnt - 1])
                                   - longint'(box_h[clip_cnt - 1]);
                            hi_x = lo_x + longint'(box_w[clip_cnt - 1]);
                            hi_y = lo_y + longint'(box_h[clip_cnt - 1]);
                        end
                    end
                ncrs_pkg::OP_PUSH_OFS:
                    if (ofs_cnt >= ncrs_pkg::OFFSET_DEPTH)
                        v.status = ncrs_pkg::ST_OFS_FULL;
                    else
                    begin
                        ofs_x[ofs_cnt] = it.shift_x;
                        ofs_y[ofs_cnt] = it.shift_y;
                        ofs_cnt++;
                        sum_x += longint'(it.shift_x);
                        sum_y += longint'(it.shift_y);
                    end
                default:
                    if (ofs_cnt == 0)
                        v.status = ncrs_pkg::ST_OFS_EMPTY;
                    else
                    begin
                        ofs_cnt--;
                        sum_x -= longint'(ofs_x[ofs_cnt]);
                        sum_y -= longint'(ofs_y[ofs_cnt]);
                    end
            endcase
            if (clip_cnt == 0)
            begin
                v.enable = 1'b0;
                v.x = 0;
                v.y = 0;
                v.w = 0;
                v.h = 0;
            end
            else
            begin
                v.enable = 1'b1;
                v.x = box_x[clip_cnt - 1];
                v.y = box_y[clip_cnt - 1];
                v.w = box_w[clip_cnt - 1];
                v.h = box_h[clip_cnt - 1];
            end
            pending_views = {pending_views, v};
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_clip(logic [2:0] st, logic en, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] w,
                                   logic signed [15:0] h);
            clip_view_t want;
            if (pending_views.size() == 0)
            begin
                $error("result transfer with nothing pending, status %0d", st);
                mismatches++;
                return;
            end
            want = pending_views.pop_front();
            if ($isunknown({st, en, x, y, w, h}))
            begin
                $error("result transfer carries unknown bits");
                mismatches++;
            end
            check_field("status", want.status, st);
            check_field("clip_enable", want.enable, en);
            check_field("clip_x", want.x, x);
            check_field("clip_y", want.y, y);
            check_field("clip_w", want.w, w);
            check_field("clip_h", want.h, h);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [14:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = ncrs_pkg::OP_PUSH_CLIP;
    logic signed [15:0] rect_x = '0;
    logic signed [15:0] rect_y = '0;
    logic signed [15:0] rect_w = '0;
    logic signed [15:0] rect_h = '0;
    logic signed [15:0] shift_x = '0;
    logic signed [15:0] shift_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic               clip_enable;
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic signed [15:0] clip_w;
    logic signed [15:0] clip_h;

    bit             in_calm = 1'b0;
    bit             out_calm = 1'b0;
    scissor_tracker sb = new();

    nested_clip_rectangle_stack_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .shift_x     (shift_x),
        .shift_y     (shift_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .clip_enable (clip_enable),
        .clip_x      (clip_x),
        .clip_y      (clip_y),
        .clip_w      (clip_w),
        .clip_h      (clip_h)
    );

    always #4 clk = ~clk;

    function automatic stack_op_t mk(ncrs_pkg::op_t o, shortint x, shortint y, shortint w,
                                     shortint h, shortint sx, shortint sy);
        stack_op_t it;
        it.op = o;
        it.rect_x = x;
        it.rect_y = y;
        it.rect_w = w;
        it.rect_h = h;
        it.shift_x = sx;
        it.shift_y = sy;
        return it;
    endfunction

    function automatic shortint pick_coord();
        if ($urandom_range(0, 3) == 0)
            return shortint'($urandom);
        return shortint'(int'($urandom_range(0, 900)) - 200);
    endfunction

    function automatic shortint pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return shortint'($urandom);
        if (r == 1)
            return shortint'(-int'($urandom_range(1, 100)));
        return shortint'($urandom_range(0, 500));
    endfunction

    function automatic shortint pick_shift();
        if ($urandom_range(0, 4) == 0)
            return shortint'($urandom);
        return shortint'(int'($urandom_range(0, 200)) - 100);
    endfunction

    function automatic stack_op_t random_op(int clip_push_pct, int ofs_push_pct);
        ncrs_pkg::op_t o;
        if ($urandom_range(0, 99) < 60)
            o = ($urandom_range(0, 99) < clip_push_pct) ? ncrs_pkg::OP_PUSH_CLIP
                                                        : ncrs_pkg::OP_POP_CLIP;
        else
            o = ($urandom_range(0, 99) < ofs_push_pct) ? ncrs_pkg::OP_PUSH_OFS
                                                       : ncrs_pkg::OP_POP_OFS;
        return mk(o, pick_coord(), pick_coord(), pick_size(), pick_size(),
                  pick_shift(), pick_shift());
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(input stack_op_t it);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        rect_x <= it.rect_x;
        rect_y <= it.rect_y;
        rect_w <= it.rect_w;
        rect_h <= it.rect_h;
        shift_x <= it.shift_x;
        shift_y <= it.shift_y;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.apply_op(it);
        @(negedge clk);
    endtask

    task automatic set_height(input logic [14:0] h);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= h;
        sb.height = h;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_views.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input int n, input int clip_push_pct, input int ofs_push_pct,
                             input bit calm_in, input bit calm_out, input logic [14:0] h);
        set_height(h);
        in_calm = calm_in;
        out_calm = calm_out;
        repeat (n) send_op(random_op(clip_push_pct, ofs_push_pct));
        in_valid <= 1'b0;
        drain();
    endtask

    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = out_calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.compare_clip(status, clip_enable, clip_x, clip_y, clip_w, clip_h);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        stack_op_t plan[$];
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_height(15'd600);

        // underflow on both stacks from reset
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_OFS, 0, 0, 0, 0, 0, 0)};
        // first clip, a nested one, then an inverted intersection
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 10, 20, 300, 200, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 100, 50, 400, 400, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 500, 500, 10, 10, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        // negative size on an empty stack
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 50, 60, -30, -20, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        // extreme offsets drive the corners far out of 16-bit range
        plan = {plan, mk(ncrs_pkg::OP_PUSH_OFS, 0, 0, 0, 0, 32767, -32768)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_OFS, 0, 0, 0, 0, 32767, -32768)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, -32768, 32767, 32767, 32767, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 32767, -32768, -32768, -32768, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_OFS, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_OFS, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_OFS, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_OFS, 0, 0, 0, 0, -32768, 32767)};
        plan = {plan, mk(ncrs_pkg::OP_PUSH_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_CLIP, 0, 0, 0, 0, 0, 0)};
        plan = {plan, mk(ncrs_pkg::OP_POP_OFS, 0, 0, 0, 0, 0, 0)};
        foreach (plan[i])
            send_op(plan[i]);
        in_valid <= 1'b0;
        drain();

        // push-heavy phases run into full stacks, pop-heavy ones back to empty
        run_phase(100, 55, 55, 1'b0, 1'b0, 15'd32767);
        run_phase(110, 85, 80, 1'b1, 1'b1, 15'($urandom_range(0, 32767)));
        run_phase(100, 20, 20, 1'b0, 1'b1, 15'd0);
        run_phase(110, 75, 70, 1'b1, 1'b0, 15'd1);
        run_phase(110, 40, 45, 1'b0, 1'b0, 15'($urandom_range(0, 32767)));

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
